@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the checker files of the RTL folder.
// No dependencies; every macro samples on the rising clock edge and
// stays quiet while the active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds, consequent holds in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent holds, consequent holds in the next cycle.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/core/hsv2rgb_pkg.sv @@
// Constants and types of the HSV to RGB converter.
// No dependencies; used by the converter and its checker.
package hsv2rgb_pkg;

  // port widths
  localparam int HUE_W   = 20;
  localparam int SV_W    = 10;
  localparam int COLOR_W = 24;

  // hue fixed point: one degree is 2**HUE_FRAC_BITS units (0..8)
  localparam int HUE_FRAC_BITS = 4;
  localparam int SECTOR        = 60 << HUE_FRAC_BITS;
  localparam int FULL_TURN     = 6 * SECTOR;

  // offset that makes any hue non-negative without changing it modulo a turn
  localparam int WRAP_K   = ((1 << (HUE_W - 1)) + FULL_TURN - 1) / FULL_TURN;
  localparam int WRAP_OFS = WRAP_K * FULL_TURN;
  localparam int U_W      = HUE_W + 1;

  // one sector is 15 << LOW_W units; hue >> LOW_W counts fifteenths of a sector
  localparam int LOW_W    = 2 + HUE_FRAC_BITS;
  localparam int W_W      = U_W - LOW_W;
  localparam int SEC_STEP = 15;
  localparam int TURN_STEP = 6 * SEC_STEP;
  localparam int RECIP    = (1 << W_W) / TURN_STEP;
  localparam int T_W      = 7;
  localparam int F_W      = 4 + LOW_W;

  // Q8 saturation / value
  localparam int Q8_W   = 9;
  localparam int Q8_ONE = 256;
  localparam int C_W    = 2 * Q8_W - 1;

  // numerator of the secondary channel over 65536 * SECTOR
  localparam int N_W    = C_W + F_W;
  localparam int X_SHIFT = 18 + HUE_FRAC_BITS;

  // 60-degree sectors, in hue order
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYA = 3'd2,
    SEC_CYA_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_e;

endpackage

@@ rtl/core/hsv_to_rgb_converter.sv @@
// HSV to RGB converter: five-stage pipeline, one item per clock unless the receiver stalls.
// Depends on hsv2rgb_pkg for widths, fixed-point constants and the sector type.
//
// Usage
//   Input channel: hue_i (signed, 1/16 degree units), saturation_i and
//   brightness_i (signed Q8, clamped to 0..1.0) move as one item when
//   in_valid_i is high and in_stall_o is low at a rising edge of clk_i.
//   Output channel: color_o (red 7:0, green 15:8, blue 23:16) moves when
//   out_valid_o is high and out_stall_i is low.
//   An accepted item passes the five register stages in order: hue wrap and
//   clamp, turn quotient and chroma multiply, sector split, channel numerators,
//   and the output register with the final scale and component ordering. One
//   item per cycle is sustained while out_stall_i stays low.
//   Each stage keeps its own valid bit, so empty slots close up when the
//   receiver stalls; in_stall_o rises only when all five stages are full and
//   out_stall_i is high. A stalled result holds on the outputs.
//   Reset (rst_ni low, asynchronous) clears all valid bits; the block keeps
//   no other state and needs no start-up time.
module hsv_to_rgb_converter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [hsv2rgb_pkg::HUE_W-1:0] hue_i,
  input  logic signed [hsv2rgb_pkg::SV_W-1:0]  saturation_i,
  input  logic signed [hsv2rgb_pkg::SV_W-1:0]  brightness_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [hsv2rgb_pkg::COLOR_W-1:0]   color_o
);
  import hsv2rgb_pkg::*;

  localparam int NSTG = 5;

  // valid bits and per-stage load enables
  logic [NSTG-1:0] vld_q, vld_d;
  logic [NSTG-1:0] rdy;

  // stage 1: wrapped hue and clamped saturation / value
  logic [U_W-1:0]  u1_q, u1_d;
  logic [Q8_W-1:0] s1_q, s1_d, v1_q, v1_d;

  // stage 2: turn quotient estimate and chroma
  logic [W_W-1:0]   w2_q, q2_q, q2_d;
  logic [LOW_W-1:0] low2_q;
  logic [C_W-1:0]   c2_q, c2_d;
  logic [Q8_W-1:0]  v2_q;
  logic [2*W_W-1:0] qprod;
  logic [2*Q8_W-1:0] cprod;

  // stage 3: sector and offset within the sector
  sector_e          sec3_q, sec3_d;
  logic [F_W-1:0]   f3_q, f3_d;
  logic [C_W-1:0]   c3_q;
  logic [Q8_W-1:0]  v3_q;
  logic [W_W-1:0]   t_raw;
  logic [T_W-1:0]   t_turn;
  logic [T_W-1:0]   t_off;
  logic [2:0]       sec_idx;

  // stage 4: secondary numerator, zero and chroma channel bytes
  sector_e          sec4_q;
  logic [N_W-1:0]   n4_q, n4_d;
  logic [7:0]       zb4_q, zb4_d, cb4_q, cb4_d;
  logic [F_W-1:0]   fp;
  logic [C_W-1:0]   z;
  logic [C_W+7:0]   z255;
  logic [Q8_W+7:0]  v255;

  // stage 5: output register
  logic [COLOR_W-1:0] color_q, color_d;
  logic [N_W+4:0]     x17;
  logic [7:0]         xb, r_b, g_b, b_b;

  // ---------------------------------------------------------------------
  // Handshake: a stage loads when it is empty or its successor moves on.
  // ---------------------------------------------------------------------
  always_comb begin
    rdy[NSTG-1] = !vld_q[NSTG-1] || !out_stall_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    vld_d[0] = rdy[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < NSTG; k++) begin
      vld_d[k] = rdy[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = vld_q[NSTG-1];
  assign color_o     = color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: lift the hue by whole turns so it is non-negative, clamp S, V.
  // ---------------------------------------------------------------------
  always_comb begin
    u1_d = U_W'({{(U_W - HUE_W){hue_i[HUE_W-1]}}, hue_i}) + U_W'(WRAP_OFS);

    if (saturation_i[SV_W-1]) begin
      s1_d = '0;
    end else if (saturation_i[SV_W-2:0] > (SV_W-1)'(Q8_ONE)) begin
      s1_d = Q8_W'(Q8_ONE);
    end else begin
      s1_d = Q8_W'(saturation_i[SV_W-2:0]);
    end

    if (brightness_i[SV_W-1]) begin
      v1_d = '0;
    end else if (brightness_i[SV_W-2:0] > (SV_W-1)'(Q8_ONE)) begin
      v1_d = Q8_W'(Q8_ONE);
    end else begin
      v1_d = Q8_W'(brightness_i[SV_W-2:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      u1_q <= u1_d;
      s1_q <= s1_d;
      v1_q <= v1_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: estimate whole turns by reciprocal multiply (may be one low),
  // form chroma C = V * S in Q16.
  // ---------------------------------------------------------------------
  always_comb begin
    qprod = (2*W_W)'(u1_q[U_W-1:LOW_W]) * (2*W_W)'(RECIP);
    q2_d  = qprod[2*W_W-1:W_W];
    cprod = (2*Q8_W)'(v1_q) * (2*Q8_W)'(s1_q);
    c2_d  = cprod[C_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      w2_q   <= u1_q[U_W-1:LOW_W];
      low2_q <= u1_q[LOW_W-1:0];
      q2_q   <= q2_d;
      c2_q   <= c2_d;
      v2_q   <= v1_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: correct the turn remainder, split it into sector and offset.
  // ---------------------------------------------------------------------
  always_comb begin
    t_raw = w2_q - W_W'(TURN_STEP) * q2_q;
    if (t_raw >= W_W'(TURN_STEP)) begin
      t_turn = T_W'(t_raw - W_W'(TURN_STEP));
    end else begin
      t_turn = T_W'(t_raw);
    end

    sec_idx = '0;
    t_off   = '0;
    for (int k = 1; k < 6; k++) begin
      if (t_turn >= T_W'(SEC_STEP * k)) begin
        sec_idx = 3'(k);
        t_off   = T_W'(SEC_STEP * k);
      end
    end

    sec3_d = sector_e'(sec_idx);
    f3_d   = {4'(t_turn - t_off), low2_q};
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      sec3_q <= sec3_d;
      f3_q   <= f3_d;
      c3_q   <= c2_q;
      v3_q   <= v2_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: numerators over 65536 * SECTOR. The chroma channel reduces to
  // 255*V/256 and the zero channel to 255*(256V - C)/65536.
  // ---------------------------------------------------------------------
  always_comb begin
    fp    = sec3_q[0] ? F_W'(SECTOR) - f3_q : f3_q;
    z     = {v3_q[C_W-9:0], 8'b0} - c3_q;
    n4_d  = N_W'(c3_q) * N_W'(fp) + N_W'(z) * N_W'(SECTOR);
    z255  = (C_W+8)'(z) * (C_W+8)'(255);
    zb4_d = z255[C_W-1+7 -: 8];
    v255  = (Q8_W+8)'(v3_q) * (Q8_W+8)'(255);
    cb4_d = v255[15:8];
  end

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      sec4_q <= sec3_q;
      n4_q   <= n4_d;
      zb4_q  <= zb4_d;
      cb4_q  <= cb4_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: 255 / (65536 * SECTOR) equals 17 / 2**X_SHIFT, so the secondary
  // channel is a constant multiply and shift. Order components by sector.
  // ---------------------------------------------------------------------
  always_comb begin
    x17 = (N_W+5)'(n4_q) * (N_W+5)'(17);
    xb  = x17[X_SHIFT+7:X_SHIFT];
    unique case (sec4_q)
      SEC_RED_YEL: begin r_b = cb4_q; g_b = xb;    b_b = zb4_q; end
      SEC_YEL_GRN: begin r_b = xb;    g_b = cb4_q; b_b = zb4_q; end
      SEC_GRN_CYA: begin r_b = zb4_q; g_b = cb4_q; b_b = xb;    end
      SEC_CYA_BLU: begin r_b = zb4_q; g_b = xb;    b_b = cb4_q; end
      SEC_BLU_MAG: begin r_b = xb;    g_b = zb4_q; b_b = cb4_q; end
      SEC_MAG_RED: begin r_b = cb4_q; g_b = zb4_q; b_b = xb;    end
      default:     begin r_b = cb4_q; g_b = zb4_q; b_b = xb;    end
    endcase
    color_d = {b_b, g_b, r_b};
  end

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      color_q <= color_d;
    end
  end

endmodule

@@ rtl/core/hsv2rgb_checker.sv @@
// Port-level checker for the HSV to RGB converter, bound into the converter module.
// Depends on hsv2rgb_pkg for port widths and on assert_macros.svh.
`include "assert_macros.svh"

module hsv2rgb_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic [hsv2rgb_pkg::HUE_W-1:0]     hue_i,
  input logic [hsv2rgb_pkg::SV_W-1:0]      saturation_i,
  input logic [hsv2rgb_pkg::SV_W-1:0]      brightness_i,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [hsv2rgb_pkg::COLOR_W-1:0]   color_o
);
  import hsv2rgb_pkg::*;

  // an accepted item, then the receiver taking results while the item moves through the stages
  sequence s_accept_flow;
    in_valid_i && !in_stall_o ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i
      ##1 !out_stall_i;
  endsequence

  // hold a stalled result
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(color_o))

  // back-pressure reaches the input only when the output is stalled
  `ASSERT_IMPLIES(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)

  // with a free-running receiver an accepted item comes out once it has passed all stages
  `ASSERT_NEXT(a_latency, clk_i, rst_ni, s_accept_flow, out_valid_o)

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_hsv2rgb_checker (.*);

@@ sim/hsv_to_rgb_converter_tb.sv @@
// Self-checking testbench for hsv_to_rgb_converter: a directed table, then random items.
// Depends on hsv2rgb_pkg and the converter RTL. It uses an integer HSV color predictor
// and checks every color in order.
`timescale 1ns / 100ps

module hsv_to_rgb_converter_tb;
  import hsv2rgb_pkg::*;

  localparam int DIR_COUNT   = 24;
  localparam int RAND_COUNT  = 850;
  localparam int ITEM_TOTAL  = DIR_COUNT + RAND_COUNT;
  localparam int HOLD_AFTER  = 300;  // colors checked before the long receiver hold
  localparam int HOLD_CYCLES = 60;   // far longer than the five-stage pipe
  localparam int DRAIN_WAIT  = 16;   // cycles after the last color, well over the latency

  // One directed row. Where known is set, color is the expected value typed in by hand.
  // Every other row goes through the predictor.
  typedef struct {
    logic signed [HUE_W-1:0] hue;
    logic signed [SV_W-1:0]  sat;
    logic signed [SV_W-1:0]  bri;
    bit                      known;
    logic [COLOR_W-1:0]      color;
  } hsv_row_t;

  // A color that is still due, with its input kept for the mismatch report.
  typedef struct {
    logic [COLOR_W-1:0]      color;
    logic signed [HUE_W-1:0] hue;
    logic signed [SV_W-1:0]  sat;
    logic signed [SV_W-1:0]  bri;
  } color_due_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic signed [HUE_W-1:0]   hue_i;
  logic signed [SV_W-1:0]    saturation_i;
  logic signed [SV_W-1:0]    brightness_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic [COLOR_W-1:0]        color_o;

  color_due_t colors_due[$];
  int         err_count      = 0;
  int         colors_checked = 0;
  logic       rx_holding;      // high while the receiver is in its long hold

  // Extremes, the six primaries, each sector boundary, hue wrap and clamping.
  // Red is in the low byte, so pure blue reads 24'hFF0000.
  hsv_row_t dir_rows [DIR_COUNT] = '{
    '{0,       0,    0,    1'b1, 24'h000000},  // black
    '{0,       0,    256,  1'b1, 24'hFFFFFF},  // white, no saturation
    '{0,       256,  256,  1'b1, 24'h0000FF},  // red
    '{960,     256,  256,  1'b1, 24'h00FFFF},  // yellow: 60 degrees opens sector one
    '{1920,    256,  256,  1'b1, 24'h00FF00},  // green
    '{2880,    256,  256,  1'b1, 24'hFFFF00},  // cyan
    '{3840,    256,  256,  1'b1, 24'hFF0000},  // blue
    '{4800,    256,  256,  1'b1, 24'hFF00FF},  // magenta
    '{5760,    256,  256,  1'b1, 24'h0000FF},  // one full turn wraps back to red
    '{-5760,   256,  256,  1'b1, 24'h0000FF},  // minus one turn, also red
    '{-1,      256,  256,  1'b0, 24'h0},       // one unit below zero wraps to the top
    '{-524288, 256,  256,  1'b0, 24'h0},       // most negative hue
    '{524287,  256,  256,  1'b0, 24'h0},       // most positive hue
    '{959,     256,  256,  1'b0, 24'h0},       // last unit of sector zero
    '{480,     -512, 256,  1'b1, 24'hFFFFFF},  // negative saturation clamps to zero
    '{480,     511,  256,  1'b0, 24'h0},       // saturation above one clamps to one
    '{480,     256,  -512, 1'b1, 24'h000000},  // negative value clamps to zero
    '{480,     256,  511,  1'b0, 24'h0},       // value above one clamps to one
    '{1000,    128,  128,  1'b0, 24'h0},
    '{3000,    300,  -1,   1'b1, 24'h000000},
    '{-524288, -512, -512, 1'b1, 24'h000000},
    '{524287,  511,  511,  1'b0, 24'h0},
    '{2000,    256,  257,  1'b0, 24'h0},
    '{-2000,   100,  200,  1'b0, 24'h0}
  };

  hsv_to_rgb_converter u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .color_o      (color_o)
  );

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Clamp a signed Q8 number into 0..1.0.
  function automatic longint q8_clamp(input logic signed [SV_W-1:0] q);
    if (q < 0) return 0;
    if (q > Q8_ONE) return Q8_ONE;
    return longint'(q);
  endfunction

  // Scale a channel numerator over den to 0..255 and truncate.
  function automatic logic [7:0] channel_byte(input longint num, input longint den);
    longint b;
    b = (255 * num) / den;
    return (b > 255) ? 8'd255 : b[7:0];
  endfunction

  // Work out the packed color exactly. Every channel is first a numerator over
  // 65536 * SECTOR, so nothing is rounded before the final scale by 255.
  function automatic logic [COLOR_W-1:0] hsv_color(input logic signed [HUE_W-1:0] hue,
                                                   input logic signed [SV_W-1:0]  sat,
                                                   input logic signed [SV_W-1:0]  bri);
    longint  h, s, v, f, c, cn, xn, mn, den, rn, gn, bn;
    sector_e sec;
    h = longint'(hue) % FULL_TURN;
    if (h < 0) h += FULL_TURN;
    s   = q8_clamp(sat);
    v   = q8_clamp(bri);
    sec = sector_e'(3'(h / SECTOR));
    f   = h % SECTOR;
    c   = v * s;
    cn  = c * SECTOR;
    // Odd sectors fall from chroma toward zero. Even sectors rise.
    xn  = ((h / SECTOR) % 2 == 1) ? c * (SECTOR - f) : c * f;
    mn  = (v * Q8_ONE - c) * SECTOR;
    den = 65536 * SECTOR;
    case (sec)
      SEC_RED_YEL: begin rn = cn; gn = xn; bn = 0;  end
      SEC_YEL_GRN: begin rn = xn; gn = cn; bn = 0;  end
      SEC_GRN_CYA: begin rn = 0;  gn = cn; bn = xn; end
      SEC_CYA_BLU: begin rn = 0;  gn = xn; bn = cn; end
      SEC_BLU_MAG: begin rn = xn; gn = 0;  bn = cn; end
      default:     begin rn = cn; gn = 0;  bn = xn; end
    endcase
    return {channel_byte(bn + mn, den), channel_byte(gn + mn, den), channel_byte(rn + mn, den)};
  endfunction

  // Draw a random Q8 value. Most fall in range, some hit 0 or 1.0 exactly, and the
  // rest cover every bit so that both clamps see plenty of use.
  function automatic logic signed [SV_W-1:0] rand_q8();
    logic [31:0] word;
    word = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2: return word[SV_W-1:0];
      3:       return $urandom_range(0, 1) ? SV_W'(Q8_ONE) : '0;
      default: return SV_W'($urandom_range(0, Q8_ONE));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Clock and run limit
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Stop a hung run. The slowest correct run takes well under a tenth of this time.
  initial begin
    #2_000_000;
    $display("%0t: timeout with %0d colors still due", $time, colors_due.size());
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: check colors and stall on a pattern of its own
  // ---------------------------------------------------------------------------
  initial begin : receiver
    color_due_t due;
    int         mode;
    int         mode_left;
    int         hold_left;
    bit         hold_done;
    bit         stall_next;
    out_stall_i = 1'b0;
    rx_holding  = 1'b0;
    mode        = 0;
    mode_left   = 50;
    hold_left   = 0;
    hold_done   = 1'b0;
    forever begin
      @(posedge clk_i);
      // Check the color accepted at this edge against the oldest one due.
      if (out_valid_o && !out_stall_i) begin
        if (colors_due.size() == 0) begin
          $display("%0t: unexpected color, expected none, got %06h", $time, color_o);
          err_count++;
        end else begin
          due = colors_due.pop_front();
          if (color_o !== due.color) begin
            $display("%0t: color mismatch for hue %0d sat %0d val %0d: expected %06h, got %06h",
                     $time, due.hue, due.sat, due.bri, due.color, color_o);
            err_count++;
          end
        end
        colors_checked++;
      end

      // Start the one long hold once enough colors have gone by. The sender keeps
      // offering items during it, so the pipe fills and stalls its input.
      if (!hold_done && colors_checked >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end

      // Change the stall pattern now and then. Mode zero gives stretches with no stall.
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 120);
      end else begin
        mode_left--;
      end

      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else begin
        case (mode)
          0:       stall_next = 1'b0;
          1:       stall_next = ($urandom_range(0, 3) == 0);
          2:       stall_next = ~out_stall_i;
          default: stall_next = ($urandom_range(0, 3) != 0);
        endcase
      end
      out_stall_i <= stall_next;
      rx_holding  <= (hold_left > 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender: reset, directed rows, random items, drain, verdict
  // ---------------------------------------------------------------------------
  initial begin : sender
    color_due_t              due;
    int                      sent;
    int                      burst_left;
    int                      gap_left;
    logic [31:0]             word;
    logic signed [HUE_W-1:0] next_hue;
    logic signed [SV_W-1:0]  next_sat;
    logic signed [SV_W-1:0]  next_bri;
    in_valid_i   = 1'b0;
    hue_i        = '0;
    saturation_i = '0;
    brightness_i = '0;
    rst_ni       = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    sent       = 0;
    burst_left = 0;
    gap_left   = 0;
    while (sent < ITEM_TOTAL) begin
      @(posedge clk_i);
      // Record the item accepted at this edge. Use the hand-typed color where
      // the row has one.
      if (in_valid_i && !in_stall_o) begin
        due.hue   = hue_i;
        due.sat   = saturation_i;
        due.bri   = brightness_i;
        due.color = (sent < DIR_COUNT && dir_rows[sent].known) ? dir_rows[sent].color
                    : hsv_color(hue_i, saturation_i, brightness_i);
        colors_due.push_back(due);
        sent++;
      end

      // Hold a stalled item. Otherwise pick the next item or a gap.
      if (!in_valid_i || !in_stall_o) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
        if (gap_left > 0 && !rx_holding) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (sent < ITEM_TOTAL) begin
          if (sent < DIR_COUNT) begin
            next_hue = dir_rows[sent].hue;
            next_sat = dir_rows[sent].sat;
            next_bri = dir_rows[sent].bri;
          end else begin
            // Draw mostly hues within a turn of zero. Some land exactly on a sector
            // boundary, and the rest cover the full 20-bit range.
            word = $urandom;
            case ($urandom_range(0, 9))
              0, 1:    next_hue = word[HUE_W-1:0];
              2:       next_hue = HUE_W'(SECTOR * (int'($urandom_range(0, 18)) - 6));
              default: next_hue = HUE_W'(int'($urandom_range(0, 2 * FULL_TURN)) - FULL_TURN);
            endcase
            next_sat = rand_q8();
            next_bri = rand_q8();
          end
          in_valid_i   <= 1'b1;
          hue_i        <= next_hue;
          saturation_i <= next_sat;
          brightness_i <= next_bri;
          burst_left--;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end

    // Wait for every color due, then leave time for a stray one to show up.
    while (colors_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Covered %0d items (%0d directed, %0d random); %0d colors checked in order,",
             sent, DIR_COUNT, sent - DIR_COUNT, colors_checked);
    $display("with bursty input, several stall patterns and one %0d-cycle receiver hold.",
             HOLD_CYCLES);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d errors", err_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
